### hdl/ple_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, codes and controller/datapath types for the positional
// list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY = 64;

    localparam int POS_W   = 6;
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 7;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [KIND_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] REQ_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic cap_req;
        logic decide;
        logic shift_rd;
        logic shift_wr;
        logic put;
        logic cnt_inc;
        logic cnt_dec;
        logic take_rd;
        logic load_out;
    } ple_cmd_t;

    typedef struct packed {
        logic err;
        logic op_ins;
        logic op_rem;
        logic op_read;
        logic at_end;
        logic out_free;
    } ple_stat_t;

endpackage
`default_nettype wire

### hdl/ple_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_req_if
// Request channel: valid/ready handshake carrying one list request.
// ----------------------------------------------------------------------------
interface ple_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [5:0]        position;
    logic signed [31:0] value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface
`default_nettype wire

### hdl/ple_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_rsp_if
// Response channel: valid/ready handshake carrying one request result.
// ----------------------------------------------------------------------------
interface ple_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;

    modport source (output valid, output status, output read_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input read_value,
                    input entry_count, output ready);
endinterface
`default_nettype wire

### hdl/ple_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: range decision, entry-by-entry shifting through the
// element memory, and hand-off to the result register.
// ----------------------------------------------------------------------------
module ple_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ple_pkg::ple_stat_t stat,
    output ple_pkg::ple_cmd_t      cmd
);
    import ple_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_LOOP   = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_WR     = 3'd4;
    localparam logic [2:0] S_PUT    = 3'd5;
    localparam logic [2:0] S_FETCH  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_req = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.err)
                    state_next = S_FINISH;
                else if (stat.op_read)
                    state_next = S_FETCH;
                else
                    state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (!stat.at_end)
                    state_next = S_RD;
                else if (stat.op_ins)
                    state_next = S_PUT;
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = S_WR;
            end
            S_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_LOOP;
            end
            S_PUT:
            begin
                cmd.put     = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = S_FINISH;
            end
            S_FETCH:
            begin
                cmd.take_rd = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

### hdl/ple_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_dpath
// Element memory, entry count, request latch, shift pointer and result
// register for the positional list engine.
// ----------------------------------------------------------------------------
module ple_dpath
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ple_pkg::ple_cmd_t cmd,
    output ple_pkg::ple_stat_t     stat,
    ple_req_if.sink                req,
    ple_rsp_if.source              rsp
);
    import ple_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [STAT_W-1:0] status_reg;
    logic [DATA_W-1:0] rd_reg;

    logic                out_valid_reg;
    logic [STAT_W-1:0]   out_status_reg;
    logic [DATA_W-1:0]   out_value_reg;
    logic [ENTRY_W-1:0]  out_count_reg;

    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  cnt_c;
    logic              range_err;
    logic              full_err;
    logic [ADDR_W-1:0] pos_a;
    logic [ADDR_W-1:0] step_a;
    logic [ADDR_W-1:0] rd_addr;

    assign pos_c = CMP_W'(pos_reg);
    assign cnt_c = CMP_W'(cnt_reg);
    assign pos_a = ADDR_W'(pos_reg);

    always_comb
    begin
        case (kind_reg)
            REQ_INSERT: range_err = (pos_c > cnt_c);
            REQ_REMOVE: range_err = (pos_c >= cnt_c);
            REQ_READ:   range_err = (pos_c >= cnt_c);
            default:    range_err = 1'b1;
        endcase
    end

    assign full_err = (kind_reg == REQ_INSERT) && !range_err
                      && (cnt_reg == CNT_W'(CAPACITY));

    assign stat.err      = range_err || full_err;
    assign stat.op_ins   = (kind_reg == REQ_INSERT);
    assign stat.op_rem   = (kind_reg == REQ_REMOVE);
    assign stat.op_read  = (kind_reg == REQ_READ);
    assign stat.at_end   = stat.op_ins ? (addr_reg == pos_a)
                                       : (addr_reg == ADDR_W'(cnt_reg - CNT_W'(1)));
    assign stat.out_free = !out_valid_reg || rsp.ready;

    // insert moves entries tailward (source below pointer), remove headward
    assign step_a  = stat.op_ins ? (addr_reg - ADDR_W'(1)) : (addr_reg + ADDR_W'(1));
    assign rd_addr = cmd.shift_rd ? step_a : pos_a;

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        if (cmd.shift_wr)
            mem[addr_reg] <= rdata_reg;
        else if (cmd.put)
            mem[pos_a] <= val_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            kind_reg <= req.req_type;
            pos_reg  <= req.position;
            val_reg  <= req.value;
        end
        if (cmd.decide)
        begin
            addr_reg   <= stat.op_rem ? pos_a : ADDR_W'(cnt_reg);
            rd_reg     <= '0;
            status_reg <= range_err ? ST_RANGE : (full_err ? ST_FULL : ST_DONE);
        end
        else
        begin
            if (cmd.shift_wr)
                addr_reg <= step_a;
            if (cmd.take_rd)
                rd_reg <= rdata_reg;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_value_reg  <= rd_reg;
            out_count_reg  <= ENTRY_W'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (cmd.cnt_dec)
                cnt_reg <= cnt_reg - CNT_W'(1);
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.entry_count = out_count_reg;

endmodule
`default_nettype wire

### hdl/positional_list_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit values with insert, remove and read at a
// position; one result per request with status, read value and count.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, position, value
//   rsp      out  valid/ready   status, read_value, entry_count
//
// After an accepted transfer each request passes S_DECIDE and ends in S_FINISH;
// a read goes through S_FETCH. Insert and remove move entries one at a time
// through the element memory, each by S_RD, S_WR and S_LOOP; an insert then
// writes the new value in S_PUT.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls only in S_FINISH while that register is still full.
// Reset empties the list at once; the element memory needs no clearing.
// ----------------------------------------------------------------------------
module positional_list_engine_core
(
    input  wire logic clk,
    input  wire logic rst_n,
    ple_req_if.sink   req,
    ple_rsp_if.source rsp
);
    import ple_pkg::*;

    ple_cmd_t  cmd;
    ple_stat_t stat;

    ple_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ple_dpath u_dpath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.entry_count <= ENTRY_W'(CAPACITY)))
        else $error("entry count above capacity");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_DONE)) |-> (rsp.read_value == '0))
        else $error("read value set on failed request");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("ready held after accepted transfer");

    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.cnt_inc && cmd.cnt_dec) && !(cmd.put && cmd.shift_wr))
        else $error("conflicting datapath commands");

endmodule
`default_nettype wire
